// ===== rtl/core/spl_pkg.sv =====
package spl_pkg;

   localparam int DATA_W           = 32;
   localparam int POS_W            = 6;
   localparam int COUNT_OUT_W      = 7;
   localparam int DEFAULT_CAPACITY = 64;

   // request op codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;

   // response status codes
   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;

   // per-cycle command broadcast to every cell
   localparam logic [1:0] CMD_HOLD   = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_SWEEP  = 2'd3;

   typedef struct packed {
      logic [1:0]              op;
      logic signed [DATA_W-1:0] pt_x;
      logic signed [DATA_W-1:0] pt_y;
      logic [POS_W-1:0]        position;
      logic signed [DATA_W-1:0] probe;
   } spl_req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic                    found;
      logic [POS_W-1:0]        found_position;
      logic signed [DATA_W-1:0] found_x;
      logic signed [DATA_W-1:0] found_y;
      logic signed [DATA_W-1:0] first_y;
      logic signed [DATA_W-1:0] final_y;
      logic [COUNT_OUT_W-1:0]  entry_count;
   } spl_rsp_type;

   typedef struct packed {
      logic [1:0]              cmd;
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] probe;
   } spl_cmd_type;

   // token that walks down the chain, collecting the tail y and the lowest match
   typedef struct packed {
      logic                    valid;
      logic                    found;
      logic [POS_W-1:0]        pos;
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] tail;
   } spl_pass_type;

endpackage

// ===== rtl/core/spl_cell.sv =====
module spl_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 7
) (
   input  logic                             clock,
   input  logic                             reset,
   input  spl_pkg::spl_cmd_type             cmd,
   input  logic [CNT_W-1:0]                 count,
   input  logic [CNT_W-1:0]                 pos,
   input  logic signed [spl_pkg::DATA_W-1:0] left_x,
   input  logic signed [spl_pkg::DATA_W-1:0] left_y,
   input  logic                             left_gt,
   input  logic signed [spl_pkg::DATA_W-1:0] right_x,
   input  logic signed [spl_pkg::DATA_W-1:0] right_y,
   input  spl_pkg::spl_pass_type            pass_right,
   output logic signed [spl_pkg::DATA_W-1:0] x,
   output logic signed [spl_pkg::DATA_W-1:0] y,
   output logic                             gt,
   output spl_pkg::spl_pass_type            pass
);

   localparam logic [CNT_W-1:0] MY_IDX   = CNT_W'(IDX);
   localparam logic [CNT_W-1:0] NEXT_IDX = CNT_W'(IDX + 1);
   localparam logic [31:0]      IDX32    = 32'(IDX);

   logic signed [spl_pkg::DATA_W-1:0] x_ff, x_in;
   logic signed [spl_pkg::DATA_W-1:0] y_ff, y_in;
   spl_pkg::spl_pass_type             pass_ff, pass_in, pass_arrive;
   logic                              occupied;
   logic                              hit;

   assign occupied = MY_IDX < count;
   assign gt       = occupied && (cmd.y < y_ff);
   assign hit      = occupied && ((x_ff == cmd.probe) || (y_ff == cmd.probe));

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      case (cmd.cmd)
         spl_pkg::CMD_INSERT: begin
            if (left_gt) begin
               x_in = left_x;
               y_in = left_y;
            end else if (gt || (MY_IDX == count)) begin
               x_in = cmd.x;
               y_in = cmd.y;
            end
         end
         spl_pkg::CMD_REMOVE: begin
            if (MY_IDX >= pos) begin
               x_in = right_x;
               y_in = right_y;
            end
         end
         default: begin
         end
      endcase
   end

   // the last occupied cell launches the token, everyone else relays it
   always_comb begin
      if ((cmd.cmd == spl_pkg::CMD_SWEEP) && (NEXT_IDX == count)) begin
         pass_arrive       = '0;
         pass_arrive.valid = 1'b1;
         pass_arrive.tail  = y_ff;
      end else begin
         pass_arrive = pass_right;
      end
      pass_in = pass_arrive;
      if (pass_arrive.valid && hit) begin
         pass_in.found = 1'b1;
         pass_in.pos   = IDX32[spl_pkg::POS_W-1:0];
         pass_in.x     = x_ff;
         pass_in.y     = y_ff;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      if (reset) begin
         pass_ff <= '0;
      end else begin
         pass_ff <= pass_in;
      end
   end

   assign x    = x_ff;
   assign y    = y_ff;
   assign pass = pass_ff;

endmodule

// ===== rtl/core/sorted_point_list.sv =====
// Insert, remove of an inner entry and unused ops load the result beat in S_POST, entered on
// the request beat; search of a non-empty table and remove of the final entry when entries
// remain load it in S_SWEEP once the token walks one cell per cycle from the tail to cell 0.
// Throughput: one request at a time; the next request beat is taken when the result beat
// leaves. Reset clears the count, the sweep token and the handshake state; point storage
// in the cells is not cleared and is never read beyond the count.
module sorted_point_list #(
   parameter int CAPACITY = spl_pkg::DEFAULT_CAPACITY
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  spl_pkg::spl_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output spl_pkg::spl_rsp_type rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > spl_pkg::POS_W) ? CNT_W : spl_pkg::POS_W;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   // control states
   localparam logic [1:0] S_IDLE  = 2'd0;  // waiting for a request beat
   localparam logic [1:0] S_POST  = 2'd1;  // table updated, answer or launch the sweep
   localparam logic [1:0] S_SWEEP = 2'd2;  // token walking toward cell 0

   logic [1:0]                         state_ff, state_in;
   logic [CNT_W-1:0]                   count_ff, count_in;
   logic signed [spl_pkg::DATA_W-1:0]  final_ff, final_in;
   logic [1:0]                         op_ff, op_in;
   logic [1:0]                         status_ff, status_in;
   logic signed [spl_pkg::DATA_W-1:0]  probe_ff, probe_in;
   logic                               sweep_ff, sweep_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   spl_pkg::spl_rsp_type               rsp_data_ff, rsp_data_in;

   logic                               accept;
   logic                               rsp_take;
   logic                               load;
   logic [CMP_W-1:0]                   pos_ext;
   logic [CMP_W-1:0]                   count_ext;
   logic                               pos_ok;
   logic                               pos_last;
   logic [CNT_W-1:0]                   cell_pos;
   logic [31:0]                        count_wide;
   spl_pkg::spl_cmd_type               cmd;

   // cell chain taps
   logic signed [spl_pkg::DATA_W-1:0]  cell_x [CAPACITY];
   logic signed [spl_pkg::DATA_W-1:0]  cell_y [CAPACITY];
   logic                               cell_gt [CAPACITY];
   spl_pkg::spl_pass_type              cell_pass [CAPACITY];

   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;

   assign pos_ext   = CMP_W'(req_data.position);
   assign count_ext = CMP_W'(count_ff);
   assign pos_ok    = pos_ext < count_ext;
   assign pos_last  = (pos_ext + CMP_W'(1)) == count_ext;
   assign cell_pos  = pos_ext[CNT_W-1:0];
   assign count_wide = 32'(count_ff);

   // command broadcast: table updates in the accept cycle, token launch in S_POST
   always_comb begin
      cmd.cmd   = spl_pkg::CMD_HOLD;
      cmd.x     = req_data.pt_x;
      cmd.y     = req_data.pt_y;
      cmd.probe = probe_ff;
      if (accept) begin
         if ((req_data.op == spl_pkg::OP_INSERT) && (count_ff < CAP_CNT)) begin
            cmd.cmd = spl_pkg::CMD_INSERT;
         end else if ((req_data.op == spl_pkg::OP_REMOVE) && pos_ok) begin
            cmd.cmd = spl_pkg::CMD_REMOVE;
         end
      end else if ((state_ff == S_POST) && sweep_ff) begin
         cmd.cmd = spl_pkg::CMD_SWEEP;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      final_in     = final_ff;
      op_in        = op_ff;
      status_in    = status_ff;
      probe_in     = probe_ff;
      sweep_in     = sweep_ff;
      load         = 1'b0;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in  = S_POST;
               op_in     = req_data.op;
               probe_in  = req_data.probe;
               status_in = spl_pkg::ST_DONE;
               sweep_in  = 1'b0;
               case (req_data.op)
                  spl_pkg::OP_INSERT: begin
                     if (count_ff < CAP_CNT) begin
                        count_in = count_ff + CNT_W'(1);
                        // new point lands at the tail unless some stored y exceeds it
                        if ((count_ff == '0) || !(req_data.pt_y < final_ff)) begin
                           final_in = req_data.pt_y;
                        end
                     end else begin
                        status_in = spl_pkg::ST_FULL;
                     end
                  end
                  spl_pkg::OP_REMOVE: begin
                     if (pos_ok) begin
                        count_in = count_ff - CNT_W'(1);
                        if (pos_last) begin
                           // tail refetched by the sweep, or table goes empty
                           final_in = '0;
                           sweep_in = count_ff > CNT_W'(1);
                        end
                     end else begin
                        status_in = spl_pkg::ST_MISSING;
                     end
                  end
                  spl_pkg::OP_SEARCH: begin
                     sweep_in = count_ff != '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_POST: begin
            if (sweep_ff) begin
               state_in = S_SWEEP;
            end else begin
               state_in                   = S_IDLE;
               load                       = 1'b1;
               rsp_data_in                = '0;
               rsp_data_in.status         = status_ff;
               rsp_data_in.first_y        = (count_ff != '0) ? cell_y[0] : '0;
               rsp_data_in.final_y        = final_ff;
               rsp_data_in.entry_count    = count_wide[spl_pkg::COUNT_OUT_W-1:0];
            end
         end
         S_SWEEP: begin
            if (cell_pass[0].valid) begin
               state_in                   = S_IDLE;
               load                       = 1'b1;
               final_in                   = cell_pass[0].tail;
               rsp_data_in                = '0;
               rsp_data_in.status         = status_ff;
               rsp_data_in.first_y        = cell_y[0];
               rsp_data_in.final_y        = cell_pass[0].tail;
               rsp_data_in.entry_count    = count_wide[spl_pkg::COUNT_OUT_W-1:0];
               if ((op_ff == spl_pkg::OP_SEARCH) && cell_pass[0].found) begin
                  rsp_data_in.found          = 1'b1;
                  rsp_data_in.found_position = cell_pass[0].pos;
                  rsp_data_in.found_x        = cell_pass[0].x;
                  rsp_data_in.found_y        = cell_pass[0].y;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         final_ff     <= '0;
         sweep_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         final_ff     <= final_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      status_ff   <= status_in;
      probe_ff    <= probe_in;
      rsp_data_ff <= rsp_data_in;
   end

   // chain of cells; cell 0 holds the smallest y
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [spl_pkg::DATA_W-1:0] lx, ly, rx, ry;
      logic                              lgt;
      spl_pkg::spl_pass_type             rpass;

      if (i == 0) begin : g_head
         assign lx  = '0;
         assign ly  = '0;
         assign lgt = 1'b0;
      end else begin : g_mid_l
         assign lx  = cell_x[i-1];
         assign ly  = cell_y[i-1];
         assign lgt = cell_gt[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign rx    = '0;
         assign ry    = '0;
         assign rpass = '0;
      end else begin : g_mid_r
         assign rx    = cell_x[i+1];
         assign ry    = cell_y[i+1];
         assign rpass = cell_pass[i+1];
      end

      spl_cell #(
         .IDX   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .count      (count_ff),
         .pos        (cell_pos),
         .left_x     (lx),
         .left_y     (ly),
         .left_gt    (lgt),
         .right_x    (rx),
         .right_y    (ry),
         .pass_right (rpass),
         .x          (cell_x[i]),
         .y          (cell_y[i]),
         .gt         (cell_gt[i]),
         .pass       (cell_pass[i])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // count never runs past the number of cells
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("entry count beyond capacity");

   // an accepted beat always moves control to the post-update state
   a_accept_post: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_POST))
      else $error("accepted beat did not reach post state");

   // a result is never loaded over one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> !rsp_valid_ff)
      else $error("result register overwritten");

   // the sweep token only reaches cell 0 while a sweep is running
   a_token_scope: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_SWEEP) |-> !cell_pass[0].valid)
      else $error("stray sweep token at head cell");

   // insert into a full table leaves the count alone
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.op == spl_pkg::OP_INSERT) && (count_ff == CAP_CNT))
      |=> (count_ff == CAP_CNT))
      else $error("insert into full table changed count");

endmodule
